FILE: hdl/acs_pkg.sv
`default_nettype none

package acs_pkg;

  localparam int MEM_DEPTH_DEF = 4096;
  localparam int ADDR_W = 12;
  localparam int DATA_W = 16;
  localparam int PC_W = 13;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [3:0] I_JNS    = 4'd0;
  localparam logic [3:0] I_LOAD   = 4'd1;
  localparam logic [3:0] I_STORE  = 4'd2;
  localparam logic [3:0] I_ADD    = 4'd3;
  localparam logic [3:0] I_SUBT   = 4'd4;
  localparam logic [3:0] I_INPUT  = 4'd5;
  localparam logic [3:0] I_OUTPUT = 4'd6;
  localparam logic [3:0] I_HALT   = 4'd7;
  localparam logic [3:0] I_SKIP   = 4'd8;
  localparam logic [3:0] I_JUMP   = 4'd9;
  localparam logic [3:0] I_CLEAR  = 4'd10;
  localparam logic [3:0] I_ADDI   = 4'd11;
  localparam logic [3:0] I_JUMPI  = 4'd12;
  localparam logic [3:0] I_LOADI  = 4'd13;
  localparam logic [3:0] I_STOREI = 4'd14;

  localparam logic [1:0] SK_NEG  = 2'd0;
  localparam logic [1:0] SK_ZERO = 2'd1;
  localparam logic [1:0] SK_POS  = 2'd2;

  localparam logic [1:0] RS_RUN  = 2'd0;
  localparam logic [1:0] RS_HALT = 2'd1;
  localparam logic [1:0] RS_PAST = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [ADDR_W-1:0]        address;
    logic [DATA_W-1:0]        load_data;
    logic signed [DATA_W-1:0] in_value;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]        read_data;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_value;
    logic                     input_used;
    logic [1:0]               run_status;
    logic [ADDR_W-1:0]        pc_now;
    logic signed [DATA_W-1:0] acc_now;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/accumulator_cpu_step.sv
// load, start and a stopped execute finish from idle; read and execute fetch a word,
// finish in decode, and a memory operand adds S_OP1, an indirect operand S_OP2;
// an item can wait in the input buffer while the one before it runs; the single-port main
// memory takes one access per cycle (fetch, operand, indirect operand or write back)
// reset clears pc and accumulator, sets status to halted, start address to 0;
// main memory is not cleared and holds garbage until written
`default_nettype none

module accumulator_cpu_step #(
  parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  acs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output acs_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [acs_pkg::ADDR_W-1:0] cfg_data
);

  import acs_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [PC_W-1:0] DEPTH_PC = PC_W'(MEM_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_OP1  = 2'd2;
  localparam logic [1:0] S_OP2  = 2'd3;

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              rd_ok;

  logic [1:0]        st, st_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic [1:0]        stat, stat_next;
  logic [ADDR_W-1:0] start_address;

  logic              ib_valid;
  item_t             ib, cur;
  logic [DATA_W-1:0] ir;
  logic              ov;
  result_t           od, res;

  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0]     mem_idx;
  logic              fin, take, adv, out_free, accept;
  logic              exec_fin, halt, used, outv;
  logic [DATA_W-1:0] rdat, word;
  logic [3:0]        code;
  logic [ADDR_W-1:0] x;
  logic [PC_W-1:0]   pc1;
  logic              neg;

  function automatic logic in_rng(input logic [ADDR_W-1:0] a);
    in_rng = {1'b0, a} < DEPTH_PC;
  endfunction

  assign out_free     = !ov || !result_stall;
  assign adv          = fin && out_free;
  assign item_stall   = ib_valid && !take;
  assign accept       = item_valid && !item_stall;
  assign result_valid = ov;
  assign result       = od;
  assign mem_idx      = mem_addr[AW-1:0];
  assign rdat         = rd_ok ? mem_q : '0;
  assign pc1          = pc + PC_W'(1);
  assign neg          = acc[DATA_W-1];

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ib.address;
    mem_wd    = ib.load_data;
    fin       = 1'b0;
    take      = 1'b0;
    st_next   = st;
    pc_next   = pc;
    acc_next  = acc;
    stat_next = stat;
    exec_fin  = 1'b0;
    halt      = 1'b0;
    used      = 1'b0;
    outv      = 1'b0;
    word      = (st == S_DEC) ? rdat : ir;
    code      = word[DATA_W-1 -: 4];
    x         = word[ADDR_W-1:0];
    res       = '0;
    case (st)
      S_IDLE: begin
        if (ib_valid) begin
          case (ib.opcode)
            OP_LOAD: begin
              fin    = 1'b1;
              take   = out_free;
              mem_we = in_rng(ib.address);
            end
            OP_START: begin
              fin       = 1'b1;
              take      = out_free;
              pc_next   = {1'b0, start_address};
              acc_next  = '0;
              stat_next = ({1'b0, start_address} >= DEPTH_PC) ? RS_PAST : RS_RUN;
            end
            OP_EXEC: begin
              if (stat != RS_RUN) begin
                fin  = 1'b1;
                take = out_free;
              end else begin
                mem_re   = 1'b1;
                mem_addr = pc[ADDR_W-1:0];
                take     = 1'b1;
                st_next  = S_DEC;
              end
            end
            default: begin
              mem_re  = 1'b1;
              take    = 1'b1;
              st_next = S_DEC;
            end
          endcase
        end
      end
      S_DEC: begin
        if (cur.opcode == OP_READ) begin
          fin           = 1'b1;
          st_next       = S_IDLE;
          res.read_data = rdat;
        end else begin
          pc_next = pc1;
          case (code)
            I_JNS: begin
              exec_fin = 1'b1;
              mem_we   = in_rng(x);
              mem_addr = x;
              mem_wd   = DATA_W'(pc1);
              pc_next  = {1'b0, x} + PC_W'(1);
            end
            I_LOAD, I_ADD, I_SUBT, I_ADDI, I_JUMPI, I_LOADI, I_STOREI: begin
              mem_re   = 1'b1;
              mem_addr = x;
              st_next  = S_OP1;
            end
            I_STORE: begin
              exec_fin = 1'b1;
              mem_we   = in_rng(x);
              mem_addr = x;
              mem_wd   = acc;
            end
            I_INPUT: begin
              exec_fin = 1'b1;
              acc_next = cur.in_value;
              used     = 1'b1;
            end
            I_OUTPUT: begin
              exec_fin = 1'b1;
              outv     = 1'b1;
            end
            I_HALT: begin
              exec_fin = 1'b1;
              halt     = 1'b1;
            end
            I_SKIP: begin
              exec_fin = 1'b1;
              if ((x[ADDR_W-1 -: 2] == SK_NEG && neg) ||
                  (x[ADDR_W-1 -: 2] == SK_ZERO && acc == '0) ||
                  (x[ADDR_W-1 -: 2] == SK_POS && !neg && acc != '0)) begin
                pc_next = pc + PC_W'(2);
              end
            end
            I_JUMP: begin
              exec_fin = 1'b1;
              pc_next  = {1'b0, x};
            end
            I_CLEAR: begin
              exec_fin = 1'b1;
              acc_next = '0;
            end
            default: begin
              exec_fin = 1'b1;
            end
          endcase
        end
      end
      S_OP1: begin
        pc_next = pc1;
        case (code)
          I_LOAD: begin
            exec_fin = 1'b1;
            acc_next = rdat;
          end
          I_ADD: begin
            exec_fin = 1'b1;
            acc_next = acc + rdat;
          end
          I_SUBT: begin
            exec_fin = 1'b1;
            acc_next = acc - rdat;
          end
          I_JUMPI: begin
            exec_fin = 1'b1;
            pc_next  = {1'b0, rdat[ADDR_W-1:0]};
          end
          I_STOREI: begin
            exec_fin = 1'b1;
            mem_we   = in_rng(rdat[ADDR_W-1:0]);
            mem_addr = rdat[ADDR_W-1:0];
            mem_wd   = acc;
          end
          default: begin
            mem_re   = 1'b1;
            mem_addr = rdat[ADDR_W-1:0];
            st_next  = S_OP2;
          end
        endcase
      end
      default: begin
        pc_next  = pc1;
        exec_fin = 1'b1;
        acc_next = (code == I_ADDI) ? acc + rdat : rdat;
      end
    endcase
    if (exec_fin) begin
      fin     = 1'b1;
      st_next = S_IDLE;
      if (halt) begin
        stat_next = RS_HALT;
      end else if (pc_next >= DEPTH_PC) begin
        stat_next = RS_PAST;
      end else begin
        stat_next = RS_RUN;
      end
    end
    res.out_valid  = outv;
    res.out_value  = outv ? acc : '0;
    res.input_used = used;
    res.run_status = stat_next;
    res.pc_now     = pc_next[ADDR_W-1:0];
    res.acc_now    = acc_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we && out_free) begin
      mem[mem_idx] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_idx];
      rd_ok <= in_rng(mem_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ib <= item;
    end
    if (take) begin
      cur <= ib;
    end
    if (st == S_DEC) begin
      ir <= rdat;
    end
    if (adv) begin
      od <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      pc            <= '0;
      acc           <= '0;
      stat          <= RS_HALT;
      start_address <= '0;
      ib_valid      <= 1'b0;
      ov            <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_address <= cfg_data;
      end
      if (accept) begin
        ib_valid <= 1'b1;
      end else if (take) begin
        ib_valid <= 1'b0;
      end
      if (!fin || out_free) begin
        st <= st_next;
      end
      if (adv) begin
        pc   <= pc_next;
        acc  <= acc_next;
        stat <= stat_next;
        ov   <= 1'b1;
      end else if (!result_stall) begin
        ov <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    stat == RS_RUN |-> pc < DEPTH_PC)
    else $error("pc out of memory while running");

  a_exec_running: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE && cur.opcode == OP_EXEC) |-> stat == RS_RUN)
    else $error("instruction in flight while stopped");

  a_op2_indirect: assert property (@(posedge clk) disable iff (rst)
    st == S_OP2 |-> (ir[DATA_W-1 -: 4] == I_ADDI || ir[DATA_W-1 -: 4] == I_LOADI))
    else $error("second operand read for a direct instruction");

  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (fin && !out_free) |=> (st == $past(st) && pc == $past(pc) && acc == $past(acc)))
    else $error("state moved while result blocked");
`endif

endmodule

`default_nettype wire
